// ----- rtl/tbc_pkg.sv -----
package tbc_pkg;

    localparam int CW      = 32;          // coordinate width
    localparam int DW      = CW + 1;      // width of a coordinate difference
    localparam int LO_W    = DW / 2;      // low slice of the multiplier operand
    localparam int HI_W    = DW - LO_W;   // high slice of the multiplier operand
    localparam int PW      = 2 * DW;      // product width
    localparam int DCNT_W  = $clog2(DW);
    localparam int MAX_V   = 7;           // vertex capacity of one buffer
    localparam int IDX_W   = $clog2(MAX_V + 1);
    localparam int NREG    = 4;
    localparam int CIDX_W  = $clog2(NREG);

    localparam logic [CIDX_W-1:0] REG_MIN_X = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_MAX_X = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] REG_MIN_Y = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] REG_MAX_Y = CIDX_W'(3);

    localparam logic signed [CW-1:0] RST_MIN = CW'(0);
    localparam logic signed [CW-1:0] RST_MAX = CW'(65536);

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic accept;
        logic pass_init;
        logic step;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic put_cross;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic tri_done;
        logic pass_end;
        logic last_pass;
        logic need_cross;
        logic div_done;
        logic emit_last;
    } status_t;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_PASS_INIT = 8'b0000_0010,
        ST_STEP      = 8'b0000_0100,
        ST_MUL_LO    = 8'b0000_1000,
        ST_MUL_HI    = 8'b0001_0000,
        ST_DIVIDE    = 8'b0010_0000,
        ST_PUT_CROSS = 8'b0100_0000,
        ST_EMIT      = 8'b1000_0000
    } state_t;

endpackage

// ----- rtl/tbc_ctrl.sv -----
module tbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  tbc_pkg::status_t  status,
    output tbc_pkg::cmd_t     cmd,
    output tbc_pkg::state_t   state
);

    tbc_pkg::state_t state_reg;
    tbc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            tbc_pkg::ST_IDLE:
            begin
                cmd.accept = 1'b1;
                if (status.tri_done)
                begin
                    state_next = tbc_pkg::ST_PASS_INIT;
                end
            end
            tbc_pkg::ST_PASS_INIT:
            begin
                cmd.pass_init = 1'b1;
                state_next    = tbc_pkg::ST_STEP;
            end
            tbc_pkg::ST_STEP:
            begin
                cmd.step = 1'b1;
                if (status.pass_end)
                begin
                    state_next = status.last_pass ? tbc_pkg::ST_EMIT : tbc_pkg::ST_PASS_INIT;
                end
                else if (status.need_cross)
                begin
                    state_next = tbc_pkg::ST_MUL_LO;
                end
            end
            tbc_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = tbc_pkg::ST_MUL_HI;
            end
            tbc_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = tbc_pkg::ST_DIVIDE;
            end
            tbc_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = tbc_pkg::ST_PUT_CROSS;
                end
            end
            tbc_pkg::ST_PUT_CROSS:
            begin
                cmd.put_cross = 1'b1;
                state_next    = tbc_pkg::ST_STEP;
            end
            tbc_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_last)
                begin
                    state_next = tbc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tbc_pkg::ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ----- rtl/tbc_datapath.sv -----
module tbc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tbc_pkg::cmd_t                 cmd,
    output tbc_pkg::status_t              status,
    input  logic                          cfg_we,
    input  logic [tbc_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [tbc_pkg::CW-1:0]        cfg_data,
    input  logic                          in_valid,
    input  tbc_pkg::coord_t               vertex_x,
    input  tbc_pkg::coord_t               vertex_y,
    input  logic                          out_stall,
    output logic                          out_valid,
    output tbc_pkg::coord_t               out_x,
    output tbc_pkg::coord_t               out_y,
    output logic                          out_last,
    output logic                          out_empty
);

    tbc_pkg::coord_t bx_reg [2][tbc_pkg::MAX_V];
    tbc_pkg::coord_t by_reg [2][tbc_pkg::MAX_V];
    logic [tbc_pkg::IDX_W-1:0] len_reg [2];

    tbc_pkg::coord_t min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [1:0]                 cnt_reg;
    logic [1:0]                 pass_reg;
    logic [tbc_pkg::IDX_W-1:0]  idx_reg;
    logic                       cross_done_reg;
    logic [tbc_pkg::DCNT_W-1:0] dcnt_reg;
    logic                       ov_reg;

    tbc_pkg::coord_t            prev_x_reg, prev_y_reg;
    logic [tbc_pkg::DW-1:0]     ma_reg, mb_reg, md_reg;
    logic                       neg_reg;
    logic [tbc_pkg::PW-1:0]     prod_reg;
    tbc_pkg::coord_t            ox_reg, oy_reg;
    logic                       olast_reg, oempty_reg;

    logic                       src, dst, axis, inv, accept;
    logic [tbc_pkg::IDX_W-1:0]  n_src, n0, rd_idx;
    logic [2:0]                 rd_sel;
    tbc_pkg::coord_t            rx, ry, c, pa, po, qa, qo;
    logic                       p_gt, p_lt, q_gt, q_lt, keep, crossing;
    logic signed [tbc_pkg::DW-1:0] num, dot, den;
    logic [tbc_pkg::DW-1:0]     mfac;
    logic [tbc_pkg::DW+tbc_pkg::HI_W-1:0] mprod;
    logic [tbc_pkg::DW:0]       dtrial, dsub;
    logic                       dge;
    logic signed [tbc_pkg::DW:0] sq, cross_o;
    tbc_pkg::coord_t            cx, cy, wx, wy;
    logic                       wr_en, load, is_last;

    assign src   = pass_reg[0];
    assign dst   = ~pass_reg[0];
    assign axis  = pass_reg[1];
    assign inv   = pass_reg[0];
    assign n_src = len_reg[src];
    assign n0    = len_reg[0];
    assign accept = cmd.accept && in_valid;

    always_comb
    begin
        case (pass_reg)
            2'd0:    c = min_x_reg;
            2'd1:    c = max_x_reg;
            2'd2:    c = min_y_reg;
            default: c = max_y_reg;
        endcase
    end

    // single read port over both buffers
    always_comb
    begin
        rd_idx = idx_reg;
        if (cmd.pass_init)
        begin
            rd_idx = (n_src == '0) ? '0 : n_src - 1'b1;
        end
        if (rd_idx >= tbc_pkg::IDX_W'(tbc_pkg::MAX_V))
        begin
            rx = '0;
            ry = '0;
        end
        else
        begin
            rx = bx_reg[cmd.emit ? 1'b0 : src][rd_idx[tbc_pkg::IDX_W-1:0]];
            ry = by_reg[cmd.emit ? 1'b0 : src][rd_idx[tbc_pkg::IDX_W-1:0]];
        end
    end
    assign rd_sel = '0;

    assign pa = axis ? ry : rx;
    assign po = axis ? rx : ry;
    assign qa = axis ? prev_y_reg : prev_x_reg;
    assign qo = axis ? prev_x_reg : prev_y_reg;

    assign p_gt = pa > c;
    assign p_lt = pa < c;
    assign q_gt = qa > c;
    assign q_lt = qa < c;
    assign keep = !(p_gt || p_lt) || (inv ? p_lt : p_gt);
    assign crossing = (p_gt && q_lt) || (p_lt && q_gt);

    assign num = {c[tbc_pkg::CW-1], c}   - {qa[tbc_pkg::CW-1], qa};
    assign dot = {po[tbc_pkg::CW-1], po} - {qo[tbc_pkg::CW-1], qo};
    assign den = {pa[tbc_pkg::CW-1], pa} - {qa[tbc_pkg::CW-1], qa};

    // shared multiplier: low slice first, high slice second
    assign mfac  = cmd.mul_hi ? tbc_pkg::DW'(mb_reg[tbc_pkg::DW-1:tbc_pkg::LO_W])
                              : tbc_pkg::DW'(mb_reg[tbc_pkg::LO_W-1:0]);
    assign mprod = ma_reg * mfac[tbc_pkg::HI_W-1:0];

    // restoring divider, one quotient bit a cycle, quotient shifts into the low half
    assign dtrial = {prod_reg[tbc_pkg::PW-1:tbc_pkg::DW], prod_reg[tbc_pkg::DW-1]};
    assign dge    = dtrial >= {1'b0, md_reg};
    assign dsub   = dtrial - {1'b0, md_reg};

    assign sq = neg_reg ? -$signed({1'b0, prod_reg[tbc_pkg::DW-1:0]})
                        :  $signed({1'b0, prod_reg[tbc_pkg::DW-1:0]});
    assign cross_o = sq + {{2{qo[tbc_pkg::CW-1]}}, qo};
    assign cx = axis ? cross_o[tbc_pkg::CW-1:0] : c;
    assign cy = axis ? c : cross_o[tbc_pkg::CW-1:0];

    assign status.tri_done   = accept && (cnt_reg == 2'd2);
    assign status.pass_end   = (idx_reg == n_src);
    assign status.last_pass  = (pass_reg == 2'd3);
    assign status.need_cross = crossing && !cross_done_reg;
    assign status.div_done   = (dcnt_reg == tbc_pkg::DCNT_W'(tbc_pkg::DW - 1));

    // output register takes a beat when empty or when the current one leaves
    assign load    = cmd.emit && (!ov_reg || !out_stall);
    assign is_last = (n0 == '0) || (idx_reg + 1'b1 == n0);
    assign status.emit_last = load && is_last;

    always_comb
    begin
        wr_en = 1'b0;
        wx    = rx;
        wy    = ry;
        if (cmd.put_cross)
        begin
            wr_en = 1'b1;
            wx    = cx;
            wy    = cy;
        end
        else if (cmd.step && !status.pass_end && !status.need_cross && keep)
        begin
            wr_en = 1'b1;
        end
        if (len_reg[dst] >= tbc_pkg::IDX_W'(tbc_pkg::MAX_V))
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg      <= tbc_pkg::RST_MIN;
            max_x_reg      <= tbc_pkg::RST_MAX;
            min_y_reg      <= tbc_pkg::RST_MIN;
            max_y_reg      <= tbc_pkg::RST_MAX;
            cnt_reg        <= '0;
            len_reg[0]     <= '0;
            len_reg[1]     <= '0;
            pass_reg       <= '0;
            idx_reg        <= '0;
            cross_done_reg <= 1'b0;
            dcnt_reg       <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tbc_pkg::REG_MIN_X: min_x_reg <= cfg_data;
                    tbc_pkg::REG_MAX_X: max_x_reg <= cfg_data;
                    tbc_pkg::REG_MIN_Y: min_y_reg <= cfg_data;
                    tbc_pkg::REG_MAX_Y: max_y_reg <= cfg_data;
                    default:            min_x_reg <= min_x_reg;
                endcase
            end
            if (accept)
            begin
                if (cnt_reg == 2'd2)
                begin
                    cnt_reg    <= '0;
                    len_reg[0] <= tbc_pkg::IDX_W'(3);
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.pass_init)
            begin
                len_reg[dst]   <= '0;
                idx_reg        <= '0;
                cross_done_reg <= 1'b0;
            end
            if (wr_en)
            begin
                len_reg[dst] <= len_reg[dst] + 1'b1;
            end
            if (cmd.step)
            begin
                if (status.pass_end)
                begin
                    pass_reg <= pass_reg + 1'b1;
                    idx_reg  <= '0;
                end
                else if (!status.need_cross)
                begin
                    idx_reg        <= idx_reg + 1'b1;
                    cross_done_reg <= 1'b0;
                end
            end
            if (cmd.mul_lo)
            begin
                dcnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (cmd.put_cross)
            begin
                cross_done_reg <= 1'b1;
            end
            if (load)
            begin
                ov_reg  <= 1'b1;
                idx_reg <= is_last ? '0 : idx_reg + 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bx_reg[0][cnt_reg] <= vertex_x;
            by_reg[0][cnt_reg] <= vertex_y;
        end
        if (wr_en)
        begin
            bx_reg[dst][len_reg[dst][tbc_pkg::IDX_W-1:0]] <= wx;
            by_reg[dst][len_reg[dst][tbc_pkg::IDX_W-1:0]] <= wy;
        end
        if (cmd.pass_init || (cmd.step && !status.pass_end && !status.need_cross))
        begin
            prev_x_reg <= rx;
            prev_y_reg <= ry;
        end
        if (cmd.step)
        begin
            ma_reg  <= num[tbc_pkg::DW-1] ? tbc_pkg::DW'(-num) : tbc_pkg::DW'(num);
            mb_reg  <= dot[tbc_pkg::DW-1] ? tbc_pkg::DW'(-dot) : tbc_pkg::DW'(dot);
            md_reg  <= den[tbc_pkg::DW-1] ? tbc_pkg::DW'(-den) : tbc_pkg::DW'(den);
            neg_reg <= num[tbc_pkg::DW-1] ^ dot[tbc_pkg::DW-1] ^ den[tbc_pkg::DW-1];
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= tbc_pkg::PW'(mprod);
        end
        if (cmd.mul_hi)
        begin
            prod_reg <= prod_reg + (tbc_pkg::PW'(mprod) << tbc_pkg::LO_W);
        end
        if (cmd.div_step)
        begin
            prod_reg <= {(dge ? dsub[tbc_pkg::DW-1:0] : dtrial[tbc_pkg::DW-1:0]),
                         prod_reg[tbc_pkg::DW-2:0], dge};
        end
        if (load)
        begin
            ox_reg     <= (n0 == '0) ? '0 : rx;
            oy_reg     <= (n0 == '0) ? '0 : ry;
            olast_reg  <= is_last;
            oempty_reg <= (n0 == '0);
        end
    end

    assign out_valid = ov_reg | (|rd_sel);
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_last  = olast_reg;
    assign out_empty = oempty_reg;

endmodule

// ----- rtl/triangle_box_clipper_top.sv -----
// The first vertex beats are only stored; the third starts four clip passes, each stepping
//   through the pass's input vertices, then the result beats follow one a cycle while
//   out_stall is low. A new triangle is taken only after its last result beat.
// Each crossing point costs a decision step, a low and a high multiply step, the shared
//   one-bit-a-cycle divider and a write.
// Reset (rst_n low, asynchronous): controller to idle, vertex count and buffer lengths
//   cleared, box registers to 0 / 65536 / 0 / 65536, no result beat pending.
module triangle_box_clipper_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tbc_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [tbc_pkg::CW-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tbc_pkg::coord_t               vertex_x,
    input  tbc_pkg::coord_t               vertex_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tbc_pkg::coord_t               out_x,
    output tbc_pkg::coord_t               out_y,
    output logic                          out_last,
    output logic                          out_empty
);

    tbc_pkg::cmd_t    cmd;
    tbc_pkg::status_t status;
    tbc_pkg::state_t  state;

    // sequencer: vertex intake, clip passes, crossing arithmetic, result beats
    tbc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .state  (state)
    );

    // vertex buffers, box registers, multiplier, divider and output register
    tbc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .vertex_x  (vertex_x),
        .vertex_y  (vertex_y),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_last  (out_last),
        .out_empty (out_empty)
    );

    // take vertex beats only while idle
    assign in_stall = !cmd.accept;

    // an empty beat is always the final one and carries a zero vertex
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty |-> out_last && out_x == '0 && out_y == '0)
        else $error("empty beat malformed");

    // the divider runs only after both multiply cycles
    a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
        state == tbc_pkg::ST_MUL_HI |=> state == tbc_pkg::ST_DIVIDE)
        else $error("divider not started after multiply");

    // a crossing point is written only right after the divider finishes
    a_put_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state == tbc_pkg::ST_PUT_CROSS |-> $past(state) == tbc_pkg::ST_DIVIDE)
        else $error("crossing put without division");

endmodule
